/* rtl/pwg_pkg.sv */
// Shared constants, register codes and the configuration struct of the
// periodic waveform generator. No dependencies.
package pwg_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int PHASE_BITS_DEF = 16;
	localparam int SINE_ADDR_BITS_DEF = 10;

	localparam int TIME_W = 32;
	localparam int PERIOD_W = 32;
	localparam int SHAPE_W = 3;
	localparam int LEVEL_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int UNI_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIPOLAR = 2'd2;

	localparam logic [SHAPE_W-1:0] SHAPE_SINE = 3'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 3'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd2;
	localparam logic [SHAPE_W-1:0] SHAPE_SAWTOOTH = 3'd3;
	localparam logic [SHAPE_W-1:0] SHAPE_JUMP = 3'd4;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1000;
	localparam logic signed [LEVEL_W:0] LVL_ONE = 17'sd16384;

	typedef struct packed {
		logic [SHAPE_W-1:0] shape;
		logic bipolar;
	} pwg_cfg_t;

endpackage

/* rtl/pwg_div.sv */
// Pipelined restoring divider: one quotient bit per stage. Forms t mod P and
// then the phase fraction floor((t mod P) * 2^PHASE_BITS / P). Uses pwg_pkg.
module pwg_div #(
	parameter int TIME_BITS = pwg_pkg::TIME_BITS_DEF,
	parameter int PHASE_BITS = pwg_pkg::PHASE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic vld_in,
	input  logic [TIME_BITS-1:0] t_in,
	input  logic [pwg_pkg::PERIOD_W-1:0] per,
	output logic vld_out,
	output logic [PHASE_BITS-1:0] p_out
);
	localparam int NSTAGE = TIME_BITS + PHASE_BITS;
	localparam int RW = pwg_pkg::PERIOD_W;

	logic [RW-1:0] rem_s [NSTAGE];
	logic [TIME_BITS-1:0] t_s [NSTAGE];
	logic [PHASE_BITS-1:0] p_s [NSTAGE];
	logic vld_s [NSTAGE];

	for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
		logic [RW-1:0] rem_prev;
		logic [TIME_BITS-1:0] t_prev;
		logic [PHASE_BITS-1:0] p_prev;
		logic vld_prev;
		logic bit_in;
		logic [RW:0] x;
		logic [RW:0] diff;
		logic ge;

		if (i == 0) begin : g_first
			assign rem_prev = '0;
			assign t_prev = t_in;
			assign p_prev = '0;
			assign vld_prev = vld_in;
		end else begin : g_next
			assign rem_prev = rem_s[i-1];
			assign t_prev = t_s[i-1];
			assign p_prev = p_s[i-1];
			assign vld_prev = vld_s[i-1];
		end

		// time bits go in MSB first, then zeros for the fraction
		if (i < TIME_BITS) begin : g_int
			assign bit_in = t_prev[TIME_BITS-1-i];
		end else begin : g_frac
			assign bit_in = 1'b0;
		end

		assign x = {rem_prev, bit_in};
		assign diff = x - {1'b0, per};
		assign ge = (x >= {1'b0, per});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i] <= ge ? diff[RW-1:0] : x[RW-1:0];
				t_s[i] <= t_prev;
				if (i >= TIME_BITS) begin
					p_s[i] <= {p_prev[PHASE_BITS-2:0], ge};
				end else begin
					p_s[i] <= p_prev;
				end
			end
		end
	end

	assign vld_out = vld_s[NSTAGE-1];
	assign p_out = p_s[NSTAGE-1];

endmodule

/* rtl/pwg_shape.sv */
// Three-stage shaper: folds the phase, reads the quarter-wave sine table,
// squares for the jump shape and scales to the output range. Uses pwg_pkg.
module pwg_shape #(
	parameter int PHASE_BITS = pwg_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_ADDR_BITS = pwg_pkg::SINE_ADDR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  pwg_pkg::pwg_cfg_t cfg,
	input  logic vld_in,
	input  logic [PHASE_BITS-1:0] p_in,
	output logic vld_out,
	output logic signed [pwg_pkg::LEVEL_W-1:0] level_out
);
	localparam int PB = PHASE_BITS;
	localparam int SA = SINE_TABLE_ADDR_BITS;
	localparam int ROM_SPAN = 1 << SA;
	localparam int UW = pwg_pkg::UNI_W;
	localparam int LW = pwg_pkg::LEVEL_W;
	localparam logic [PB-1:0] HALF = {1'b1, {(PB-1){1'b0}}};
	localparam logic [2*PB-1:0] HH = {2'b01, {(2*PB-2){1'b0}}};
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [13] = '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72,
		64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};

	typedef logic [UW-1:0] rom_t [ROM_SPAN+1];

	// Q30 Taylor series of sin over the first quadrant, rounded to Q14
	function automatic rom_t fill_rom();
		rom_t r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic signed [63:0] val;
		for (int k = 0; k <= ROM_SPAN; k++) begin
			x = (PI_HALF_Q30 * 64'(k)) / ROM_SPAN;
			x2 = (x * x) >> 30;
			term = x;
			sum = $signed(x);
			for (int n = 1; n <= 12; n++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[n];
				if (n % 2 == 1) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			val = (sum * 64'sd16384 + 64'sd536870912) >>> 30;
			if (val > 64'sd16384) begin
				val = 64'sd16384;
			end
			r[k] = val[UW-1:0];
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = fill_rom();

	// stage 1: fold phase, table address, simple shapes
	logic [PB-1:0] u;
	logic [PB-1:0] v;
	logic [PB+14:0] tri_w;
	logic [PB+13:0] saw_w;
	logic [SA-1:0] idx;
	logic [SA:0] addr;
	logic [UW-1:0] uni_c;

	assign u = (p_in <= HALF) ? p_in : (~p_in + 1'b1);
	assign v = HALF - u;
	assign tri_w = {u, 15'd0};
	assign saw_w = {p_in, 14'd0};

	if (PB - 2 >= SA) begin : g_idx_trunc
		assign idx = p_in[PB-3 -: SA];
	end else begin : g_idx_pad
		assign idx = {p_in[PB-3:0], {(SA-PB+2){1'b0}}};
	end

	// odd quadrants read the table mirrored
	assign addr = p_in[PB-2] ? ((SA+1)'(ROM_SPAN) - {1'b0, idx}) : {1'b0, idx};

	always_comb begin
		unique case (cfg.shape)
			pwg_pkg::SHAPE_SQUARE:   uni_c = (p_in < HALF) ? UW'(16384) : '0;
			pwg_pkg::SHAPE_TRIANGLE: uni_c = tri_w[PB+14:PB];
			pwg_pkg::SHAPE_SAWTOOTH: uni_c = {1'b0, saw_w[PB+13:PB]};
			default:                 uni_c = '0;
		endcase
	end

	logic vld_s1, vld_s2, vld_s3;
	logic [PB-1:0] v_s1;
	logic [SA:0] addr_s1;
	logic neg_s1, neg_s2;
	logic [UW-1:0] uni_s1, uni_s2;
	logic [2*PB-1:0] vv_s2;
	logic [UW-1:0] rom_s2;
	logic signed [LW-1:0] level_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1 <= v;
			addr_s1 <= addr;
			neg_s1 <= p_in[PB-1];
			uni_s1 <= uni_c;
		end
	end

	// stage 2: table read and square for the jump shape
	always_ff @(posedge clk) begin
		if (adv) begin
			vv_s2 <= v_s1 * v_s1;
			rom_s2 <= SINE_ROM[addr_s1];
			neg_s2 <= neg_s1;
			uni_s2 <= uni_s1;
		end
	end

	// stage 3: jump level, range scaling
	logic [2*PB-1:0] jdiff;
	logic [UW-1:0] uni;
	logic signed [LW:0] s;
	logic signed [LW:0] uni_x;
	logic signed [LW:0] lvl_c;

	assign jdiff = HH - vv_s2;
	assign uni = (cfg.shape == pwg_pkg::SHAPE_JUMP) ? jdiff[2*PB-2 -: UW] : uni_s2;
	assign s = neg_s2 ? -$signed({2'b00, rom_s2}) : $signed({2'b00, rom_s2});
	assign uni_x = $signed({2'b00, uni});

	always_comb begin
		unique case (cfg.shape)
			pwg_pkg::SHAPE_SINE:
				lvl_c = cfg.bipolar ? s : ((s + pwg_pkg::LVL_ONE) >>> 1);
			pwg_pkg::SHAPE_SQUARE, pwg_pkg::SHAPE_TRIANGLE,
			pwg_pkg::SHAPE_SAWTOOTH, pwg_pkg::SHAPE_JUMP:
				lvl_c = cfg.bipolar ? ((uni_x <<< 1) - pwg_pkg::LVL_ONE) : uni_x;
			default:
				lvl_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_s3 <= lvl_c[LW-1:0];
		end
	end

	assign vld_out = vld_s3;
	assign level_out = level_s3;

endmodule

/* rtl/periodic_waveform_generator.sv */
// Top level of the periodic waveform generator: configuration registers,
// pipeline stall control, divider and shaper. Uses pwg_pkg, pwg_div, pwg_shape.
//
// Each accepted time word gives one level word, in order: the divider spends one
// stage per quotient bit, TIME_BITS for t mod period and PHASE_BITS for the
// phase fraction, then three stages fold, look up the sine table, square and
// scale. A new word is taken every cycle; the whole pipeline holds while the
// output word waits. The user must write configuration only while the
// pipeline is empty; the block itself does not enforce this. A period of zero
// is stored as one.
module periodic_waveform_generator #(
	parameter int TIME_BITS = pwg_pkg::TIME_BITS_DEF,
	parameter int PHASE_BITS = pwg_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_ADDR_BITS = pwg_pkg::SINE_ADDR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [pwg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic [pwg_pkg::TIME_W-1:0] time_ticks,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [pwg_pkg::LEVEL_W-1:0] level
);
	logic [pwg_pkg::PERIOD_W-1:0] period_q;
	logic [pwg_pkg::SHAPE_W-1:0] shape_q;
	logic bipolar_q;
	pwg_pkg::pwg_cfg_t cfg;
	logic adv;
	logic [TIME_BITS-1:0] t_in;
	logic div_vld;
	logic [PHASE_BITS-1:0] div_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= pwg_pkg::PERIOD_RESET;
			shape_q <= pwg_pkg::SHAPE_SINE;
			bipolar_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pwg_pkg::REG_PERIOD:
					period_q <= (cfg_data == '0) ? pwg_pkg::PERIOD_W'(1) : cfg_data;
				pwg_pkg::REG_SHAPE:   shape_q <= cfg_data[pwg_pkg::SHAPE_W-1:0];
				pwg_pkg::REG_BIPOLAR: bipolar_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.shape = shape_q;
	assign cfg.bipolar = bipolar_q;

	// advance everything unless the output word is held
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	if (TIME_BITS > pwg_pkg::TIME_W) begin : g_t_wide
		assign t_in = {{(TIME_BITS-pwg_pkg::TIME_W){1'b0}}, time_ticks};
	end else begin : g_t_narrow
		assign t_in = time_ticks[TIME_BITS-1:0];
	end

	pwg_div #(
		.TIME_BITS(TIME_BITS),
		.PHASE_BITS(PHASE_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.vld_in(in_valid),
		.t_in(t_in),
		.per(period_q),
		.vld_out(div_vld),
		.p_out(div_p)
	);

	pwg_shape #(
		.PHASE_BITS(PHASE_BITS),
		.SINE_TABLE_ADDR_BITS(SINE_TABLE_ADDR_BITS)
	) u_shape (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.cfg(cfg),
		.vld_in(div_vld),
		.p_in(div_p),
		.vld_out(out_valid),
		.level_out(level)
	);

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level <= 16'sd16384 && level >= -16'sd16384))
		else $error("level out of range");

	a_unipolar: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !bipolar_q) |-> (level >= 16'sd0))
		else $error("negative level in unipolar range");

	a_unused_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && shape_q > pwg_pkg::SHAPE_JUMP) |-> (level == 16'sd0))
		else $error("unused shape code gave nonzero level");

	a_square: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && shape_q == pwg_pkg::SHAPE_SQUARE && bipolar_q)
		|-> (level == 16'sd16384 || level == -16'sd16384))
		else $error("bipolar square not at full scale");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the periodic waveform generator.
// Drives time words and configuration writes, predicts each level word
// from its own model, and compares in order. Depends on rtl/pwg_pkg.sv and rtl/periodic_waveform_generator.sv.
`timescale 1ns / 1ps

module testbench;

	localparam int LATENCY = 51;
	localparam int SETTLE = LATENCY + 10;
	localparam int WATCHDOG = 5000;
	// index past the last register, and a shape code past the last shape
	localparam logic [pwg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [pwg_pkg::SHAPE_W-1:0] SHAPE_UNUSED = 3'd5;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [pwg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pwg_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [pwg_pkg::TIME_W-1:0] time_ticks;
	logic out_valid;
	logic out_ready;
	logic signed [pwg_pkg::LEVEL_W-1:0] level;

	periodic_waveform_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.time_ticks(time_ticks),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level(level)
	);

	// model registers
	logic [pwg_pkg::PERIOD_W-1:0] mdl_period;
	logic [pwg_pkg::SHAPE_W-1:0] mdl_shape;
	logic mdl_bipolar;
	int sine_quarter[0:1024];

	logic signed [pwg_pkg::LEVEL_W-1:0] pending_levels[$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int settings_used = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int holdoff_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// quarter-wave sine table, Q30 Taylor series rounded to 16384 full scale
	task automatic build_sine_table();
		longint unsigned x, x2, term;
		longint sum, val;
		for (int k = 0; k <= 1024; k++) begin
			x = (64'd1686629713 * k) / 1024;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int n = 1; n <= 12; n++) begin
				term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
				if (n % 2)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			val = (sum * 16384 + (64'sd1 << 29)) >>> 30;
			if (val > 16384)
				val = 16384;
			sine_quarter[k] = int'(val);
		end
	endtask

	function automatic logic signed [pwg_pkg::LEVEL_W-1:0] calc_level(
		logic [pwg_pkg::TIME_W-1:0] t);
		longint unsigned per, r, p, u, v, idx, quad;
		longint unsigned half;
		longint unsigned full;
		int uni, s, lvl;
		half = 64'd32768;
		full = 64'd65536;
		per = (mdl_period == 0) ? 64'd1 : 64'(mdl_period);
		r = 64'(t) % per;
		p = (r << 16) / per;
		u = (p <= half) ? p : full - p;
		uni = 0;
		case (mdl_shape)
			pwg_pkg::SHAPE_SINE: begin
				quad = (p >> 14) & 3;
				idx = ((p & 16383) >> 4) & 1023;
				if (quad & 1)
					idx = 1024 - idx;
				s = sine_quarter[idx];
				if (quad & 2)
					s = -s;
				lvl = mdl_bipolar ? s : ((s + 16384) >>> 1);
			end
			pwg_pkg::SHAPE_SQUARE, pwg_pkg::SHAPE_TRIANGLE,
			pwg_pkg::SHAPE_SAWTOOTH, pwg_pkg::SHAPE_JUMP: begin
				if (mdl_shape == pwg_pkg::SHAPE_SQUARE)
					uni = (p < half) ? 16384 : 0;
				else if (mdl_shape == pwg_pkg::SHAPE_TRIANGLE)
					uni = int'((u << 15) >> 16);
				else if (mdl_shape == pwg_pkg::SHAPE_SAWTOOTH)
					uni = int'((p << 14) >> 16);
				else begin
					v = half - u;
					uni = int'(((half * half - v * v) << 14) >> 30);
				end
				lvl = mdl_bipolar ? (2 * uni - 16384) : uni;
			end
			default: lvl = 0;
		endcase
		return lvl[pwg_pkg::LEVEL_W-1:0];
	endfunction

	task automatic send_time(logic [pwg_pkg::TIME_W-1:0] t);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		time_ticks <= t;
		do @(posedge clk); while (!in_ready);
		pending_levels.push_back(calc_level(t));
		words_sent++;
	endtask

	// hold the sender until every level word is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [pwg_pkg::CFG_IDX_W-1:0] idx,
		logic [pwg_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == pwg_pkg::REG_PERIOD)
			mdl_period = data;
		else if (idx == pwg_pkg::REG_SHAPE)
			mdl_shape = data[pwg_pkg::SHAPE_W-1:0];
		else if (idx == pwg_pkg::REG_BIPOLAR)
			mdl_bipolar = data[0];
	endtask

	task automatic apply_setting(logic [31:0] per, logic [pwg_pkg::SHAPE_W-1:0] shp,
		logic bip);
		drain();
		write_reg(pwg_pkg::REG_PERIOD, per);
		write_reg(pwg_pkg::REG_SHAPE, 32'(shp));
		write_reg(pwg_pkg::REG_BIPOLAR, 32'(bip));
		settings_used++;
	endtask

	function automatic logic [31:0] pick_period();
		case ($urandom_range(5))
			0: return $urandom_range(1, 16);
			1: return $urandom_range(17, 5000);
			2: return $urandom;
			3: return 32'hFFFF_FFFF;
			4: return 32'd0;
			default: return 32'd65536;
		endcase
	endfunction

	function automatic logic [31:0] pick_time(logic [31:0] per);
		logic [31:0] k;
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 4000);
			2: return 32'hFFFF_FFFF - $urandom_range(0, 200);
			default: begin
				k = $urandom_range(0, 7);
				return k * per + $urandom_range(0, 3) - 1;
			end
		endcase
	endfunction

	task automatic set_traffic(int src, int dst);
		sender_idle_pct = src;
		receiver_stall_pct = dst;
	endtask

	task automatic test_directed();
		logic [31:0] times[6];
		times = '{32'd0, 32'hFFFF_FFFF, 32'd999, 32'd500, 32'd250, 32'd750};
		set_traffic(0, 0);
		// reset settings: period 1000, sine, unipolar
		foreach (times[i])
			send_time(times[i]);
		for (int shp = 1; shp <= 4; shp++)
			for (int bip = 0; bip <= 1; bip++) begin
				apply_setting(32'd1000, shp[pwg_pkg::SHAPE_W-1:0], bip[0]);
				send_time(32'd0);
				send_time(32'd499);
			end
		apply_setting(32'd0, pwg_pkg::SHAPE_SAWTOOTH, 1'b1);
		send_time(32'hFFFF_FFFF);
		// unused shape codes, and excess bits masked away
		drain();
		write_reg(pwg_pkg::REG_SHAPE, 32'hFFFF_FFFD);
		write_reg(pwg_pkg::REG_BIPOLAR, 32'h0000_0002);
		send_time(32'd123);
		drain();
		write_reg(pwg_pkg::REG_SHAPE, 32'd7);
		write_reg(REG_UNUSED, 32'd1);
		send_time(32'h8000_0000);
	endtask

	task automatic test_random_settings();
		logic [31:0] per;
		int mode;
		for (int n = 0; n < 16; n++) begin
			per = pick_period();
			apply_setting(per,
				$urandom_range(0, 7) < 7 ? 3'($urandom_range(0, 4)) : SHAPE_UNUSED,
				1'($urandom_range(1)));
			mode = n % 4;
			case (mode)
				0: set_traffic(0, 0);
				1: set_traffic(59, 0);
				2: set_traffic(0, 59);
				default: set_traffic(35, 35);
			endcase
			for (int i = 0; i < 42; i++)
				send_time(pick_time(per));
		end
	endtask

	task automatic test_backpressure();
		apply_setting(32'd777, pwg_pkg::SHAPE_TRIANGLE, 1'b1);
		set_traffic(0, 0);
		holdoff_cycles <= 300;
		for (int i = 0; i < 80; i++)
			send_time($urandom);
	endtask

	task automatic test_pause();
		set_traffic(35, 35);
		for (int i = 0; i < 20; i++)
			send_time($urandom);
		drain();
		for (int i = 0; i < 20; i++)
			send_time($urandom);
	endtask

	// receiver: random stall, or a long hold-off on request
	always @(posedge clk) begin
		if (holdoff_cycles > 0) begin
			out_ready <= 1'b0;
			holdoff_cycles <= holdoff_cycles - 1;
		end else
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				$error("level: unexpected word, actual %0d", level);
				errors++;
			end else begin
				if (level !== pending_levels[0]) begin
					$error("level: expected %0d, actual %0d", pending_levels[0], level);
					errors++;
				end
				void'(pending_levels.pop_front());
				words_checked++;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no word moved in %0d cycles", WATCHDOG);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		time_ticks = '0;
		out_ready = 1'b0;
		mdl_period = pwg_pkg::PERIOD_RESET;
		mdl_shape = pwg_pkg::SHAPE_SINE;
		mdl_bipolar = 1'b0;
		build_sine_table();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_settings();
		test_backpressure();
		test_pause();
		drain();
		$display("%0d time words sent, %0d levels checked, %0d register settings,",
			words_sent, words_checked, settings_used);
		$display("all shapes, both ranges, zero and extreme periods, stalls and hold-off");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
